/* hw/rtl/wrc_pkg.sv */
package wrc_pkg;

   // default geometry
   localparam int INPUT_BITS_DEF  = 64;
   localparam int TUPLE_BITS_DEF  = 8;
   localparam int CLASS_COUNT_DEF = 10;

   // fixed field widths
   localparam int ACTION_W        = 2;
   localparam int SAMPLE_W        = 64;
   localparam int LABEL_W         = 4;
   localparam int MAP_W           = 6;
   localparam int MAP_DEPTH       = 64;
   localparam int VOTE_W          = 4;
   localparam int NUM_VOTE_FIELDS = 10;

   localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_MAP = 2'd0,
      ACT_TRAIN    = 2'd1,
      ACT_PREDICT  = 2'd2
   } action_type;

   typedef logic [VOTE_W-1:0] vote_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic map_write;
      logic capture;
      logic build_addr;
      logic train_step;
      logic read_step;
      logic load_out;
   } wrc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic sweep_last;
      logic out_free;
   } wrc_status_type;

endpackage

/* hw/rtl/wrc_intf.sv */
interface wrc_req_if import wrc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SAMPLE_W-1:0] sample_bits;
   logic [LABEL_W-1:0]  class_label;
   logic [MAP_W-1:0]    map_slot;
   logic [MAP_W-1:0]    map_source;

   modport source (output valid, action, sample_bits, class_label, map_slot, map_source,
                   input ready);
   modport sink   (input valid, action, sample_bits, class_label, map_slot, map_source,
                   output ready);
endinterface

interface wrc_rsp_if import wrc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [VOTE_W-1:0] votes_class_0;
   logic [VOTE_W-1:0] votes_class_1;
   logic [VOTE_W-1:0] votes_class_2;
   logic [VOTE_W-1:0] votes_class_3;
   logic [VOTE_W-1:0] votes_class_4;
   logic [VOTE_W-1:0] votes_class_5;
   logic [VOTE_W-1:0] votes_class_6;
   logic [VOTE_W-1:0] votes_class_7;
   logic [VOTE_W-1:0] votes_class_8;
   logic [VOTE_W-1:0] votes_class_9;

   modport source (output valid, votes_class_0, votes_class_1, votes_class_2, votes_class_3,
                   votes_class_4, votes_class_5, votes_class_6, votes_class_7,
                   votes_class_8, votes_class_9, input ready);
   modport sink   (input valid, votes_class_0, votes_class_1, votes_class_2, votes_class_3,
                   votes_class_4, votes_class_5, votes_class_6, votes_class_7,
                   votes_class_8, votes_class_9, output ready);
endinterface

/* hw/rtl/weightless_ram_classifier.sv */
// channel   | dir | modport | carries
// ----------+-----+---------+--------------------------------------------------
// req_in    | in  | sink    | action, sample_bits, class_label, map_slot, map_source
// rsp_out   | out | source  | votes_class_0 .. votes_class_9, predict only
//
// one transaction is worked at a time; the shared mark store has one port, so the
// sweep visits one ram per cycle (RAM_COUNT = INPUT_BITS / TUPLE_BITS)
// map load is taken in idle; train goes through address build and sweep; predict then flushes and hands off
// after reset the mark store is cleared one word a cycle, all RAM_COUNT * 2**TUPLE_BITS
// words (2048 at the defaults), with req_in.ready low throughout
// the vote result sits in an output register; a new transaction is taken while it
// waits, and a second predict only holds in its last step until rsp_out drains
module weightless_ram_classifier import wrc_pkg::*; #(
   parameter int INPUT_BITS  = INPUT_BITS_DEF,
   parameter int TUPLE_BITS  = TUPLE_BITS_DEF,
   parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   wrc_req_if.sink   req_in,
   wrc_rsp_if.source rsp_out
);

   wrc_cmd_type    cmd;
   wrc_status_type status;
   vote_type       votes [NUM_VOTE_FIELDS];

   // sequencer: clear pass, accept, address build, ram sweep, result hand-off
   wrc_ctrl #(
      .CLASS_COUNT (CLASS_COUNT)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_in.valid),
      .req_action      (req_in.action),
      .req_class_label (req_in.class_label),
      .req_ready       (req_in.ready),
      .status          (status),
      .cmd             (cmd)
   );

   // mapping table, tuple addresses, mark store, vote counters, output register
   wrc_datapath #(
      .INPUT_BITS  (INPUT_BITS),
      .TUPLE_BITS  (TUPLE_BITS),
      .CLASS_COUNT (CLASS_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample_bits (req_in.sample_bits),
      .req_class_label (req_in.class_label),
      .req_map_slot    (req_in.map_slot),
      .req_map_source  (req_in.map_source),
      .rsp_ready       (rsp_out.ready),
      .rsp_valid       (rsp_out.valid),
      .rsp_votes       (votes)
   );

   // unused classes already read as zero out of the datapath
   assign rsp_out.votes_class_0 = votes[0];
   assign rsp_out.votes_class_1 = votes[1];
   assign rsp_out.votes_class_2 = votes[2];
   assign rsp_out.votes_class_3 = votes[3];
   assign rsp_out.votes_class_4 = votes[4];
   assign rsp_out.votes_class_5 = votes[5];
   assign rsp_out.votes_class_6 = votes[6];
   assign rsp_out.votes_class_7 = votes[7];
   assign rsp_out.votes_class_8 = votes[8];
   assign rsp_out.votes_class_9 = votes[9];

endmodule

/* hw/rtl/wrc_ctrl.sv */
module wrc_ctrl import wrc_pkg::*; #(
   parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [LABEL_W-1:0]  req_class_label,
   output logic                req_ready,
   input  wrc_status_type      status,
   output wrc_cmd_type         cmd
);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_ADDR  = 6'b000100,
      S_SWEEP = 6'b001000,
      S_FLUSH = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      train_ff, train_in;
   logic      accept;
   logic      label_ok;
   logic      is_train;
   logic      is_predict;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign label_ok   = (req_class_label < LABEL_W'(CLASS_COUNT));
   assign is_train   = (req_action == ACT_TRAIN);
   assign is_predict = (req_action == ACT_PREDICT);

   always_comb begin
      state_in = state_ff;
      train_in = train_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.map_write = accept && (req_action == ACT_LOAD_MAP);
            // bad label trains nothing, so it never leaves idle
            if (accept && (is_predict || (is_train && label_ok))) begin
               cmd.capture = 1'b1;
               train_in    = is_train;
               state_in    = S_ADDR;
            end
         end
         S_ADDR: begin
            cmd.build_addr = 1'b1;
            state_in       = S_SWEEP;
         end
         S_SWEEP: begin
            cmd.train_step = train_ff;
            cmd.read_step  = !train_ff;
            if (status.sweep_last) begin
               state_in = train_ff ? S_IDLE : S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         train_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         train_ff <= train_in;
      end
   end

endmodule

/* hw/rtl/wrc_datapath.sv */
module wrc_datapath import wrc_pkg::*; #(
   parameter int INPUT_BITS  = INPUT_BITS_DEF,
   parameter int TUPLE_BITS  = TUPLE_BITS_DEF,
   parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  wrc_cmd_type         cmd,
   output wrc_status_type      status,
   input  logic [SAMPLE_W-1:0] req_sample_bits,
   input  logic [LABEL_W-1:0]  req_class_label,
   input  logic [MAP_W-1:0]    req_map_slot,
   input  logic [MAP_W-1:0]    req_map_source,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output vote_type            rsp_votes [NUM_VOTE_FIELDS]
);

   localparam int RAM_COUNT   = INPUT_BITS / TUPLE_BITS;
   localparam int MAP_USED    = RAM_COUNT * TUPLE_BITS;
   localparam int RAM_IDX_W   = (RAM_COUNT > 1) ? $clog2(RAM_COUNT) : 1;
   localparam int ST_ADDR_W   = RAM_IDX_W + TUPLE_BITS;
   localparam int STORE_DEPTH = RAM_COUNT * (2 ** TUPLE_BITS);
   localparam int CLS_IDX_W   = $clog2(CLASS_COUNT);

   logic [MAP_W-1:0]       map_ff     [MAP_USED];
   logic [MAP_W-1:0]       map_in     [MAP_USED];
   logic [INPUT_BITS-1:0]  sample_ff, sample_in;
   logic [MAP_DEPTH-1:0]   sample_ext;
   logic [CLS_IDX_W-1:0]   label_ff, label_in;
   logic [TUPLE_BITS-1:0]  tuple      [RAM_COUNT];
   logic [TUPLE_BITS-1:0]  addr_ff    [RAM_COUNT];
   logic [TUPLE_BITS-1:0]  addr_in    [RAM_COUNT];
   logic [RAM_IDX_W-1:0]   ram_cnt_ff, ram_cnt_in;
   logic [ST_ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [ST_ADDR_W-1:0]   st_addr;
   logic                   step;
   logic [CLASS_COUNT-1:0] mark_mem   [STORE_DEPTH];
   logic [CLASS_COUNT-1:0] rd_data_ff;
   logic                   rd_valid_ff;
   vote_type               acc_ff     [CLASS_COUNT];
   vote_type               acc_in     [CLASS_COUNT];
   vote_type               votes_ff   [NUM_VOTE_FIELDS];
   vote_type               votes_in   [NUM_VOTE_FIELDS];
   logic                   out_valid_ff, out_valid_in;

   assign step    = cmd.train_step || cmd.read_step;
   assign st_addr = {ram_cnt_ff, addr_ff[0]};

   // mapping table load, writes to slots past the used range are dropped
   always_comb begin
      for (int k = 0; k < MAP_USED; k++) begin
         map_in[k] = (cmd.map_write && (req_map_slot == MAP_W'(k))) ? req_map_source
                                                                     : map_ff[k];
      end
   end

   assign sample_in  = cmd.capture ? req_sample_bits[INPUT_BITS-1:0] : sample_ff;
   assign label_in   = cmd.capture ? req_class_label[CLS_IDX_W-1:0] : label_ff;
   // positions beyond the sample read as zero
   assign sample_ext = MAP_DEPTH'(sample_ff);

   // tuple address of every ram
   always_comb begin
      for (int r = 0; r < RAM_COUNT; r++) begin
         for (int j = 0; j < TUPLE_BITS; j++) begin
            tuple[r][j] = sample_ext[map_ff[r * TUPLE_BITS + j]];
         end
      end
   end

   // address line shifts one ram per sweep step
   always_comb begin
      for (int r = 0; r < RAM_COUNT; r++) begin
         if (cmd.build_addr) begin
            addr_in[r] = tuple[r];
         end else if (step && (r < RAM_COUNT - 1)) begin
            addr_in[r] = addr_ff[(r + 1) % RAM_COUNT];
         end else begin
            addr_in[r] = addr_ff[r];
         end
      end
   end

   always_comb begin
      ram_cnt_in = ram_cnt_ff;
      if (cmd.build_addr) begin
         ram_cnt_in = '0;
      end else if (step) begin
         ram_cnt_in = ram_cnt_ff + RAM_IDX_W'(1);
      end
   end

   assign clr_addr_in = cmd.clear_step ? clr_addr_ff + ST_ADDR_W'(1) : clr_addr_ff;

   assign status.clear_last = (clr_addr_ff == ST_ADDR_W'(STORE_DEPTH - 1));
   assign status.sweep_last = (ram_cnt_ff == RAM_IDX_W'(RAM_COUNT - 1));
   assign status.out_free   = !out_valid_ff || rsp_ready;

   // saturating vote counters
   always_comb begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
         if (cmd.build_addr) begin
            acc_in[c] = '0;
         end else if (rd_valid_ff && rd_data_ff[c] && (acc_ff[c] != VOTE_MAX)) begin
            acc_in[c] = acc_ff[c] + VOTE_W'(1);
         end else begin
            acc_in[c] = acc_ff[c];
         end
      end
   end

   for (genvar c = 0; c < NUM_VOTE_FIELDS; c++) begin : g_vote
      if (c < CLASS_COUNT) begin : g_used
         assign votes_in[c] = cmd.load_out ? acc_ff[c] : votes_ff[c];
      end else begin : g_unused
         assign votes_in[c] = '0;
      end
      assign rsp_votes[c] = votes_ff[c];
   end

   assign out_valid_in = cmd.load_out || (out_valid_ff && !rsp_ready);
   assign rsp_valid    = out_valid_ff;

   // mark store, one port
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mark_mem[clr_addr_ff] <= '0;
      end else if (cmd.train_step) begin
         mark_mem[st_addr][label_ff] <= 1'b1;
      end
      if (cmd.read_step) begin
         rd_data_ff <= mark_mem[st_addr];
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      label_ff  <= label_in;
      addr_ff   <= addr_in;
      acc_ff    <= acc_in;
      votes_ff  <= votes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAP_USED; k++) begin
            map_ff[k] <= MAP_W'(k);
         end
         ram_cnt_ff   <= '0;
         clr_addr_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         map_ff       <= map_in;
         ram_cnt_ff   <= ram_cnt_in;
         clr_addr_ff  <= clr_addr_in;
         rd_valid_ff  <= cmd.read_step;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* hw/rtl/wrc_checker.sv */
module wrc_checker import wrc_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [ACTION_W-1:0]           req_action,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [NUM_VOTE_FIELDS*VOTE_W-1:0] rsp_votes
);

   // result held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_votes))
      else $error("rsp transaction dropped or changed while stalled");

   // clear pass keeps the input closed right after reset
   a_clear_closed: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high during mark store clear");

   // a predict occupies the block for its sweep
   a_predict_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_PREDICT) |=> !req_ready)
      else $error("req_ready high right after a predict transaction");

   // no result appears the cycle after an accept
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("rsp transaction too soon after req transaction");

endmodule

bind weightless_ram_classifier wrc_checker u_wrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_in.valid),
   .req_ready  (req_in.ready),
   .req_action (req_in.action),
   .rsp_valid  (rsp_out.valid),
   .rsp_ready  (rsp_out.ready),
   .rsp_votes  ({rsp_out.votes_class_9, rsp_out.votes_class_8, rsp_out.votes_class_7,
                 rsp_out.votes_class_6, rsp_out.votes_class_5, rsp_out.votes_class_4,
                 rsp_out.votes_class_3, rsp_out.votes_class_2, rsp_out.votes_class_1,
                 rsp_out.votes_class_0})
);

/* tb/sv/testbench.sv */
module testbench;
   import wrc_pkg::*;

   // geometry of the instance under test, the package defaults
   localparam int RAM_COUNT   = INPUT_BITS_DEF / TUPLE_BITS_DEF;
   localparam int RAM_WORDS   = 1 << TUPLE_BITS_DEF;
   localparam int MARK_WORDS  = RAM_COUNT * RAM_WORDS;
   localparam int RANDOM_ITEMS = 1480;
   localparam int CALM_ITEMS  = 200;

   // the one action code the block has no name for, it must be dropped silently
   localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

   // vote fields packed with class 0 in the low nibble
   typedef logic [NUM_VOTE_FIELDS-1:0][VOTE_W-1:0] vote_row_type;

   // mirror of the mapping table and the shared mark store, plus the votes owed
   class vote_ledger;
      logic [MAP_W-1:0]           bit_map [MAP_DEPTH];
      logic [NUM_VOTE_FIELDS-1:0] class_marks [MARK_WORDS];
      vote_row_type               owed_votes [$];
      int                         failures;

      function new();
         for (int k = 0; k < MAP_DEPTH; k++) bit_map[k] = MAP_W'(k);
         for (int w = 0; w < MARK_WORDS; w++) class_marks[w] = '0;
         failures = 0;
      endfunction

      // mark store index for one ram, address bits picked through the mapping
      function int unsigned mark_index(logic [SAMPLE_W-1:0] sample, int ram);
         int unsigned addr;
         int          pos;
         addr = 0;
         for (int j = 0; j < TUPLE_BITS_DEF; j++) begin
            pos = bit_map[(ram * TUPLE_BITS_DEF + j) % MAP_DEPTH];
            if (pos < INPUT_BITS_DEF && sample[pos]) addr |= 1 << j;
         end
         return ram * RAM_WORDS + addr;
      endfunction

      function void note_request(logic [ACTION_W-1:0] act, logic [SAMPLE_W-1:0] sample,
                                 logic [LABEL_W-1:0] label, logic [MAP_W-1:0] slot,
                                 logic [MAP_W-1:0] source);
         vote_row_type tally;
         int unsigned  count;
         case (act)
            ACT_LOAD_MAP: begin
               bit_map[slot] = source;
            end
            ACT_TRAIN: begin
               if (label < CLASS_COUNT_DEF)
                  for (int r = 0; r < RAM_COUNT; r++)
                     class_marks[mark_index(sample, r)][label] = 1'b1;
            end
            ACT_PREDICT: begin
               tally = '0;
               for (int c = 0; c < NUM_VOTE_FIELDS && c < CLASS_COUNT_DEF; c++) begin
                  count = 0;
                  for (int r = 0; r < RAM_COUNT; r++)
                     count += class_marks[mark_index(sample, r)][c];
                  tally[c] = (count > VOTE_MAX) ? VOTE_MAX : VOTE_W'(count);
               end
               owed_votes = {owed_votes, tally};
            end
            default: ;
         endcase
      endfunction

      function void check_votes(vote_row_type got);
         vote_row_type want;
         if (owed_votes.size() == 0) begin
            $error("vote result with no predict outstanding");
            failures++;
            return;
         end
         want = owed_votes.pop_front();
         for (int c = 0; c < NUM_VOTE_FIELDS; c++)
            if (got[c] !== want[c]) begin
               $error("votes_class_%0d expected %0d actual %0d", c, want[c], got[c]);
               failures++;
            end
      endfunction

      function int outstanding();
         return owed_votes.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;   // final stretch of the run, no idling on either side

   wrc_req_if req_if ();
   wrc_rsp_if rsp_if ();

   weightless_ram_classifier dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_if),
      .rsp_out (rsp_if)
   );

   vote_ledger ledger = new();

   // 8 unit clock period
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hard stop, well past the slowest legal run including the store clear
   initial begin
      #4_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   // every accepted vote transaction is checked against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         ledger.check_votes({rsp_if.votes_class_9, rsp_if.votes_class_8,
                             rsp_if.votes_class_7, rsp_if.votes_class_6,
                             rsp_if.votes_class_5, rsp_if.votes_class_4,
                             rsp_if.votes_class_3, rsp_if.votes_class_2,
                             rsp_if.votes_class_1, rsp_if.votes_class_0});
   end

   // result side back-pressure: ready stretches broken by stall bursts
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         if (calm || $urandom_range(0, 2) != 0) begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   // present one transaction and hold it until the block takes it
   task automatic offer(logic [ACTION_W-1:0] act, logic [SAMPLE_W-1:0] sample,
                        logic [LABEL_W-1:0] label, logic [MAP_W-1:0] slot,
                        logic [MAP_W-1:0] source);
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.sample_bits <= sample;
      req_if.class_label <= label;
      req_if.map_slot    <= slot;
      req_if.map_source  <= source;
      do @(posedge clock); while (!req_if.ready);
      ledger.note_request(act, sample, label, slot, source);
   endtask

   // sender gap, action, sample and label are scrambled while valid is low
   task automatic hold_off(int cycles);
      req_if.valid       <= 1'b0;
      req_if.action      <= ACTION_W'($urandom());
      req_if.sample_bits <= {$urandom(), $urandom()};
      req_if.class_label <= LABEL_W'($urandom());
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] wide_random();
      return {$urandom(), $urandom()};
   endfunction

   // copy of a sample with a few random bit positions flipped
   function automatic logic [SAMPLE_W-1:0] jitter(logic [SAMPLE_W-1:0] s, int flips);
      for (int i = 0; i < flips; i++) s[$urandom_range(0, SAMPLE_W - 1)] ^= 1'b1;
      return s;
   endfunction

   initial begin
      logic [SAMPLE_W-1:0] protos [12];
      logic [LABEL_W-1:0]  proto_label [12];
      logic [SAMPLE_W-1:0] s;
      int                  p;
      int                  roll;
      int                  counted;
      int                  idle_odds;

      // all inputs known from time zero, reset asserted first
      reset              = 1'b1;
      calm               = 1'b0;
      req_if.valid       = 1'b0;
      req_if.action      = ACT_LOAD_MAP;
      req_if.sample_bits = '0;
      req_if.class_label = '0;
      req_if.map_slot    = '0;
      req_if.map_source  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store votes nothing
      offer(ACT_PREDICT, '0, 4'd0, 6'd0, 6'd0);
      offer(ACT_PREDICT, '1, 4'd15, 6'd63, 6'd63);
      // label extremes and a few patterns
      offer(ACT_TRAIN, '0, 4'd0, 6'd17, 6'd42);
      offer(ACT_TRAIN, '1, 4'd9, 6'd5, 6'd9);
      offer(ACT_TRAIN, 64'h5555_5555_5555_5555, 4'd3, 6'd0, 6'd0);
      // labels past the last class must leave the store alone
      offer(ACT_TRAIN, 64'hAAAA_AAAA_AAAA_AAAA, 4'd10, 6'd0, 6'd0);
      offer(ACT_TRAIN, 64'hAAAA_AAAA_AAAA_AAAA, 4'd15, 6'd63, 6'd63);
      offer(ACT_PREDICT, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0, 6'd0, 6'd0);
      offer(ACT_PREDICT, '0, 4'd0, 6'd0, 6'd0);
      offer(ACT_PREDICT, '1, 4'd0, 6'd0, 6'd0);
      offer(ACT_PREDICT, 64'h5555_5555_5555_5555, 4'd0, 6'd0, 6'd0);
      // near matches: each differs from one trained pattern in one ram
      offer(ACT_PREDICT, 64'h0000_0000_0000_00FF, 4'd0, 6'd0, 6'd0);
      offer(ACT_PREDICT, 64'hFF55_5555_5555_5555, 4'd0, 6'd0, 6'd0);
      // unknown action with every field busy
      offer(ACT_IGNORED, '1, 4'd15, 6'd63, 6'd63);
      offer(ACT_PREDICT, '1, 4'd0, 6'd0, 6'd0);
      // mapping extremes, first and last entry, then one bit read twice
      offer(ACT_LOAD_MAP, '0, 4'd0, 6'd0, 6'd63);
      offer(ACT_LOAD_MAP, '1, 4'd15, 6'd63, 6'd0);
      offer(ACT_LOAD_MAP, '0, 4'd0, 6'd8, 6'd63);
      offer(ACT_PREDICT, 64'h8000_0000_0000_0000, 4'd0, 6'd0, 6'd0);
      offer(ACT_PREDICT, 64'h0000_0000_0000_0001, 4'd0, 6'd0, 6'd0);
      offer(ACT_TRAIN, 64'h8000_0000_0000_0001, 4'd7, 6'd0, 6'd0);
      // back to back predicts, the second may wait on the output register
      offer(ACT_PREDICT, 64'h8000_0000_0000_0001, 4'd0, 6'd0, 6'd0);
      offer(ACT_PREDICT, '1, 4'd0, 6'd0, 6'd0);

      // random: prototypes trained and queried with jitter so votes spread out
      for (int i = 0; i < 12; i++) begin
         protos[i]      = wide_random();
         proto_label[i] = LABEL_W'($urandom_range(0, CLASS_COUNT_DEF - 1));
      end
      counted   = 0;
      idle_odds = 4;
      while (counted < RANDOM_ITEMS) begin
         if (counted >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         // idle density changes in phases, including phases with none at all
         if (counted % 50 == 0) idle_odds = $urandom_range(0, 3);
         if (!calm && idle_odds != 0 && $urandom_range(0, 7) < idle_odds)
            hold_off($urandom_range(1, 14));
         if ($urandom_range(0, 99) == 0) begin
            p              = $urandom_range(0, 11);
            protos[p]      = wide_random();
            proto_label[p] = LABEL_W'($urandom_range(0, CLASS_COUNT_DEF - 1));
         end
         p    = $urandom_range(0, 11);
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            offer(ACT_LOAD_MAP, wide_random(), LABEL_W'($urandom()), MAP_W'($urandom()),
                  MAP_W'($urandom()));
            counted++;
         end else if (roll < 10) begin
            // ignored by the block, not counted
            offer(ACT_IGNORED, wide_random(), LABEL_W'($urandom()), MAP_W'($urandom()),
                  MAP_W'($urandom()));
         end else if (roll < 14) begin
            offer(ACT_TRAIN, jitter(protos[p], 2),
                  LABEL_W'($urandom_range(CLASS_COUNT_DEF, 15)),
                  MAP_W'($urandom()), MAP_W'($urandom()));
         end else if (roll < 44) begin
            s = jitter(protos[p], $urandom_range(0, 3));
            offer(ACT_TRAIN, s,
                  LABEL_W'(($urandom_range(0, 4) == 0) ?
                           $urandom_range(0, CLASS_COUNT_DEF - 1) : proto_label[p]),
                  MAP_W'($urandom()), MAP_W'($urandom()));
            counted++;
         end else if (roll < 52) begin
            offer(ACT_PREDICT, wide_random(), LABEL_W'($urandom()), MAP_W'($urandom()),
                  MAP_W'($urandom()));
            counted++;
         end else begin
            offer(ACT_PREDICT, jitter(protos[p], $urandom_range(0, 12)),
                  LABEL_W'($urandom()), MAP_W'($urandom()), MAP_W'($urandom()));
            counted++;
         end
      end
      req_if.valid <= 1'b0;

      // drain owed votes, then give the last transaction time to misbehave
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (ledger.failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/wrc_pkg.sv
hw/rtl/wrc_intf.sv
hw/rtl/wrc_ctrl.sv
hw/rtl/wrc_datapath.sv
hw/rtl/weightless_ram_classifier.sv
hw/rtl/wrc_checker.sv
tb/sv/testbench.sv
